/* hdl/sdspi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants for the SD card SPI host.
// Holds the phase and operation codes, the item mode and status codes,
// the command frame constants and the result record.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // Widths fixed by the register and field definitions.
  localparam int RetryW  = 20;
  localparam int PollW   = 8;
  localparam int SectorW = 23;
  localparam int AddrW   = 32;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_READ = 2'd1,
    MODE_XFER = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Completion status codes.
  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_INIT_OK   = 2'd1,
    ST_INIT_FAIL = 2'd2,
    ST_READ_DONE = 2'd3
  } status_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_WAKE  = 4'd1,
    PH_PRE   = 4'd2,
    PH_CMD   = 4'd3,
    PH_POLL  = 4'd4,
    PH_TRAIL = 4'd5,
    PH_DESEL = 4'd6,
    PH_TOKEN = 4'd7,
    PH_DATA  = 4'd8,
    PH_TAIL  = 4'd9
  } phase_t;

  // Operation in progress.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INIT = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Register indexes on the configuration port.
  localparam logic REG_RETRY_LIMIT    = 1'b0;
  localparam logic REG_RESPONSE_POLLS = 1'b1;

  localparam logic [RetryW-1:0] RetryLimitReset    = 20'hFFFFF;
  localparam logic [PollW-1:0]  ResponsePollsReset = 8'd8;

  // Command frame constants.
  localparam logic [7:0] IdleByte   = 8'hFF;
  localparam logic [7:0] TokenByte  = 8'hFE;
  localparam logic [7:0] Cmd0Byte   = 8'h40;
  localparam logic [7:0] Cmd0Crc    = 8'h95;
  localparam logic [7:0] Cmd1Byte   = 8'h41;
  localparam logic [7:0] Cmd1Crc    = 8'hF9;
  localparam logic [7:0] Cmd16Byte  = 8'h50;
  localparam logic [7:0] Cmd17Byte  = 8'h51;
  localparam logic [7:0] DummyCrc   = 8'hFF;
  localparam logic [7:0] RespIdle   = 8'h01;
  localparam logic [7:0] RespReady  = 8'h00;
  localparam logic [AddrW-1:0] Cmd16Arg = 32'h0000_0200;

  // Frame lengths in bytes.
  localparam int PreBytes  = 3;
  localparam int CmdBytes  = 6;
  localparam int PostBytes = 3;
  localparam int TailBytes = 3;

  // One result item.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       want_transfer;
    logic       select_card;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last_data;
    status_t    status;
    logic       fast_clock;
  } res_t;

endpackage

/* hdl/sd_spi_init_and_block_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_read: SD card SPI-mode host, init and sector read.
// Top level: configuration registers, byte sequencer and result buffer.
// ----------------------------------------------------------------------------
// Results are registered, or kept in the skid stage while the output is held.
// Throughput: one item per cycle while in_stall is low; each byte is decided
// combinationally and the two-entry result buffer absorbs one stalled result.
// Reset (synchronous): sequencer idle, slow clock, retry_limit 0xFFFFF,
// response_polls 8, result buffer empty.
module sd_spi_init_and_block_read #(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [22:0] sector,
  input  logic [7:0]  rx_byte,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        want_transfer,
  output logic        select_card,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic        last_data,
  output logic [1:0]  status,
  output logic        fast_clock
);

  logic [sdspi_pkg::RetryW-1:0] retry_limit;
  logic [sdspi_pkg::PollW-1:0]  response_polls;
  logic                         cfg_write;
  logic                         in_go;
  sdspi_pkg::res_t              eng_res;
  sdspi_pkg::res_t              out_res;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit    <= sdspi_pkg::RetryLimitReset;
      response_polls <= sdspi_pkg::ResponsePollsReset;
    end else if (cfg_write) begin
      case (paddr[2])
        sdspi_pkg::REG_RETRY_LIMIT:    retry_limit    <= pwdata[sdspi_pkg::RetryW-1:0];
        sdspi_pkg::REG_RESPONSE_POLLS: response_polls <= pwdata[sdspi_pkg::PollW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      sdspi_pkg::REG_RETRY_LIMIT:    prdata = 32'(retry_limit);
      sdspi_pkg::REG_RESPONSE_POLLS: prdata = 32'(response_polls);
      default:                       prdata = '0;
    endcase
  end

  // Input transfer.
  assign in_go = in_valid && !in_stall;

  sdspi_engine #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .WAKE_BYTES  (WAKE_BYTES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .in_go          (in_go),
    .mode           (mode),
    .sector         (sector),
    .rx_byte        (rx_byte),
    .retry_limit    (retry_limit),
    .response_polls (response_polls),
    .result         (eng_res)
  );

  sdspi_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_go),
    .push_data (eng_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Result fields.
  assign tx_byte       = out_res.tx_byte;
  assign want_transfer = out_res.want_transfer;
  assign select_card   = out_res.select_card;
  assign data_valid    = out_res.data_valid;
  assign data_byte     = out_res.data_byte;
  assign last_data     = out_res.last_data;
  assign status        = out_res.status;
  assign fast_clock    = out_res.fast_clock;

endmodule

/* hdl/sdspi_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_engine: byte-level sequencer of the SD card SPI host.
// Updates the sequencer state for each accepted item and forms the result
// for that item in the same cycle.
// ----------------------------------------------------------------------------
module sdspi_engine #(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_go,
  input  logic [1:0]                   mode,
  input  logic [sdspi_pkg::SectorW-1:0] sector,
  input  logic [7:0]                   rx_byte,
  input  logic [sdspi_pkg::RetryW-1:0] retry_limit,
  input  logic [sdspi_pkg::PollW-1:0]  response_polls,
  output sdspi_pkg::res_t              result
);

  localparam int CountMax = (BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES;
  localparam int CountW   = $clog2(CountMax + 1);

  // Sequencer state.
  sdspi_pkg::phase_t               phase, phase_next;
  sdspi_pkg::op_t                  operation, operation_next;
  logic [1:0]                      command_step, command_step_next;
  logic [CountW-1:0]               byte_count, byte_count_next;
  logic [sdspi_pkg::RetryW-1:0]    retry_count, retry_count_next;
  logic [sdspi_pkg::PollW-1:0]     poll_count, poll_count_next;
  logic [7:0]                      last_response, last_response_next;
  logic [sdspi_pkg::AddrW-1:0]     address_latch, address_latch_next;
  logic                            clock_fast, clock_fast_next;

  // Shared decode.
  logic                         xfer;
  logic [sdspi_pkg::RetryW-1:0] lim_retry, retry_inc;
  logic [sdspi_pkg::PollW-1:0]  lim_polls, poll_inc;
  logic [CountW-1:0]            byte_inc;
  logic                         expect_ok, step_done, desel_end;
  logic                         finish_read, finish_init;

  assign xfer      = in_go && (mode == sdspi_pkg::MODE_XFER) && (phase != sdspi_pkg::PH_IDLE);
  assign lim_retry = (retry_limit == '0) ? sdspi_pkg::RetryW'(1) : retry_limit;
  assign lim_polls = (response_polls == '0) ? sdspi_pkg::PollW'(1) : response_polls;
  assign retry_inc = retry_count + 1'b1;
  assign poll_inc  = poll_count + 1'b1;
  assign byte_inc  = byte_count + 1'b1;
  assign expect_ok = (command_step == 2'd0) ? (last_response == sdspi_pkg::RespIdle)
                                            : (last_response == sdspi_pkg::RespReady);
  assign step_done = expect_ok || (retry_inc >= lim_retry);
  assign desel_end = xfer && (phase == sdspi_pkg::PH_DESEL) &&
                     (byte_inc >= CountW'(sdspi_pkg::PostBytes));
  assign finish_read = desel_end && (operation == sdspi_pkg::OP_READ);
  assign finish_init = desel_end && (operation != sdspi_pkg::OP_READ) && step_done &&
                       (command_step >= 2'd2);

  // Next state.
  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    command_step_next  = command_step;
    byte_count_next    = byte_count;
    retry_count_next   = retry_count;
    poll_count_next    = poll_count;
    last_response_next = last_response;
    address_latch_next = address_latch;
    clock_fast_next    = clock_fast;
    if (in_go && (mode == sdspi_pkg::MODE_INIT)) begin
      clock_fast_next    = 1'b0;
      operation_next     = sdspi_pkg::OP_INIT;
      phase_next         = sdspi_pkg::PH_WAKE;
      command_step_next  = 2'd0;
      byte_count_next    = '0;
      retry_count_next   = '0;
      poll_count_next    = '0;
      last_response_next = '0;
    end else if (in_go && (mode == sdspi_pkg::MODE_READ)) begin
      operation_next     = sdspi_pkg::OP_READ;
      address_latch_next = {sector, 9'd0};
      phase_next         = sdspi_pkg::PH_PRE;
      byte_count_next    = '0;
      retry_count_next   = '0;
      poll_count_next    = '0;
    end else if (xfer) begin
      case (phase)
        sdspi_pkg::PH_WAKE: begin
          byte_count_next = byte_inc;
          if (byte_inc >= CountW'(WAKE_BYTES)) begin
            phase_next      = sdspi_pkg::PH_PRE;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_PRE: begin
          byte_count_next = byte_inc;
          if (byte_inc >= CountW'(sdspi_pkg::PreBytes)) begin
            phase_next      = sdspi_pkg::PH_CMD;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_CMD: begin
          byte_count_next = byte_inc;
          if (byte_inc >= CountW'(sdspi_pkg::CmdBytes)) begin
            phase_next      = sdspi_pkg::PH_POLL;
            byte_count_next = '0;
            poll_count_next = '0;
          end
        end
        sdspi_pkg::PH_POLL: begin
          poll_count_next    = poll_inc;
          last_response_next = rx_byte;
          if (!rx_byte[7] || (poll_inc >= lim_polls)) begin
            phase_next = sdspi_pkg::PH_TRAIL;
          end
        end
        sdspi_pkg::PH_TRAIL: begin
          byte_count_next = '0;
          if (operation == sdspi_pkg::OP_READ) begin
            phase_next       = sdspi_pkg::PH_TOKEN;
            retry_count_next = '0;
          end else begin
            phase_next = sdspi_pkg::PH_DESEL;
          end
        end
        sdspi_pkg::PH_DESEL: begin
          byte_count_next = byte_inc;
          if (desel_end) begin
            byte_count_next = '0;
            if (finish_read) begin
              phase_next     = sdspi_pkg::PH_IDLE;
              operation_next = sdspi_pkg::OP_NONE;
            end else begin
              // Retry the command, move to the next one, or conclude.
              retry_count_next = retry_inc;
              if (step_done) begin
                if (command_step < 2'd2) begin
                  command_step_next = command_step + 2'd1;
                  retry_count_next  = '0;
                  phase_next        = sdspi_pkg::PH_PRE;
                end else begin
                  clock_fast_next = (last_response == sdspi_pkg::RespReady);
                  phase_next      = sdspi_pkg::PH_IDLE;
                  operation_next  = sdspi_pkg::OP_NONE;
                end
              end else begin
                phase_next = sdspi_pkg::PH_PRE;
              end
            end
          end
        end
        sdspi_pkg::PH_TOKEN: begin
          retry_count_next = retry_inc;
          if ((rx_byte == sdspi_pkg::TokenByte) || (retry_inc >= lim_retry)) begin
            phase_next      = sdspi_pkg::PH_DATA;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_DATA: begin
          byte_count_next = byte_inc;
          if (byte_inc >= CountW'(BLOCK_BYTES)) begin
            phase_next      = sdspi_pkg::PH_TAIL;
            byte_count_next = '0;
          end
        end
        sdspi_pkg::PH_TAIL: begin
          byte_count_next = byte_inc;
          if (byte_inc >= CountW'(sdspi_pkg::TailBytes)) begin
            phase_next      = sdspi_pkg::PH_DESEL;
            byte_count_next = '0;
          end
        end
        default: begin
          phase_next      = sdspi_pkg::PH_IDLE;
          operation_next  = sdspi_pkg::OP_NONE;
          byte_count_next = '0;
        end
      endcase
    end
  end

  // Result for the accepted item.
  always_comb begin
    logic [7:0]                  cmd, crc;
    logic [sdspi_pkg::AddrW-1:0] arg;
    if (operation_next == sdspi_pkg::OP_READ) begin
      cmd = sdspi_pkg::Cmd17Byte;
      arg = address_latch_next;
      crc = sdspi_pkg::DummyCrc;
    end else if (command_step_next == 2'd0) begin
      cmd = sdspi_pkg::Cmd0Byte;
      arg = '0;
      crc = sdspi_pkg::Cmd0Crc;
    end else if (command_step_next == 2'd1) begin
      cmd = sdspi_pkg::Cmd1Byte;
      arg = '0;
      crc = sdspi_pkg::Cmd1Crc;
    end else begin
      cmd = sdspi_pkg::Cmd16Byte;
      arg = sdspi_pkg::Cmd16Arg;
      crc = sdspi_pkg::DummyCrc;
    end

    result.tx_byte       = sdspi_pkg::IdleByte;
    result.want_transfer = 1'b1;
    result.select_card   = 1'b1;
    case (phase_next)
      sdspi_pkg::PH_IDLE: begin
        result.want_transfer = 1'b0;
        result.select_card   = 1'b0;
      end
      sdspi_pkg::PH_WAKE, sdspi_pkg::PH_DESEL: begin
        result.select_card = 1'b0;
      end
      sdspi_pkg::PH_CMD: begin
        case (byte_count_next)
          CountW'(0): result.tx_byte = cmd;
          CountW'(1): result.tx_byte = arg[31:24];
          CountW'(2): result.tx_byte = arg[23:16];
          CountW'(3): result.tx_byte = arg[15:8];
          CountW'(4): result.tx_byte = arg[7:0];
          default:    result.tx_byte = crc;
        endcase
      end
      default: begin
        result.tx_byte = sdspi_pkg::IdleByte;
      end
    endcase

    result.data_valid = xfer && (phase == sdspi_pkg::PH_DATA);
    result.data_byte  = result.data_valid ? rx_byte : 8'd0;
    result.last_data  = result.data_valid && (byte_inc >= CountW'(BLOCK_BYTES));
    if (finish_read) begin
      result.status = sdspi_pkg::ST_READ_DONE;
    end else if (finish_init) begin
      result.status = (last_response == sdspi_pkg::RespReady) ? sdspi_pkg::ST_INIT_OK
                                                              : sdspi_pkg::ST_INIT_FAIL;
    end else begin
      result.status = sdspi_pkg::ST_BUSY;
    end
    result.fast_clock = clock_fast_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdspi_pkg::PH_IDLE;
      operation     <= sdspi_pkg::OP_NONE;
      command_step  <= 2'd0;
      byte_count    <= '0;
      retry_count   <= '0;
      poll_count    <= '0;
      last_response <= '0;
      address_latch <= '0;
      clock_fast    <= 1'b0;
    end else begin
      phase         <= phase_next;
      operation     <= operation_next;
      command_step  <= command_step_next;
      byte_count    <= byte_count_next;
      retry_count   <= retry_count_next;
      poll_count    <= poll_count_next;
      last_response <= last_response_next;
      address_latch <= address_latch_next;
      clock_fast    <= clock_fast_next;
    end
  end

  // A sector byte is only ever produced with the card selected.
  a_data_selected: assert property (@(posedge clk) disable iff (rst)
    result.data_valid |-> result.select_card)
    else $error("sector byte delivered with card deselected");

  // A completion status leaves the engine idle.
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (result.status != sdspi_pkg::ST_BUSY) |-> !result.want_transfer)
    else $error("completion status while a transfer is still requested");

  // The completion leaves the state idle on the next cycle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (in_go && (result.status != sdspi_pkg::ST_BUSY)) |=> (phase == sdspi_pkg::PH_IDLE))
    else $error("engine not idle after completion");

  // The final byte flag only comes with a sector byte.
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    result.last_data |-> result.data_valid)
    else $error("last byte flag without a sector byte");

endmodule

/* hdl/sdspi_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_outq: result register with a skid stage.
// Holds results while the receiver stalls so that the input side can take
// one more item before it has to stall.
// ----------------------------------------------------------------------------
module sdspi_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sdspi_pkg::res_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output sdspi_pkg::res_t out_data
);

  logic            skid_valid;
  sdspi_pkg::res_t skid_data;
  logic            pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Control: the skid stage fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  // The skid stage is only occupied behind a waiting result.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result ahead of the output register");

  // A transfer into a held output register lands in the skid stage.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && out_stall) |=> skid_valid)
    else $error("result lost while the output was stalled");

endmodule

/* tb/tb_sd_spi_init_and_block_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_init_and_block_read: self-checking bench for the SD SPI host.
// A behavioural card answers each transfer from the predicted host state, so
// most traffic is well-formed initialisation and sector reads with random
// content, mixed with restarts and stray items. Every accepted item is run
// through a local model of the host and the resulting output is checked
// against the block, field by field, in transfer order.
// ----------------------------------------------------------------------------
module tb_sd_spi_init_and_block_read;

  localparam int BlockBytes = 512;
  localparam int WakeBytes  = 10;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 200;
  localparam int NumPhases  = 7;

  // Fixed outputs that can be read straight off the host behaviour.
  localparam sdspi_pkg::res_t ResIdle = '{
    tx_byte: sdspi_pkg::IdleByte, want_transfer: 1'b0, select_card: 1'b0,
    data_valid: 1'b0, data_byte: 8'h00, last_data: 1'b0,
    status: sdspi_pkg::ST_BUSY, fast_clock: 1'b0};
  localparam sdspi_pkg::res_t ResSelected = '{
    tx_byte: sdspi_pkg::IdleByte, want_transfer: 1'b1, select_card: 1'b1,
    data_valid: 1'b0, data_byte: 8'h00, last_data: 1'b0,
    status: sdspi_pkg::ST_BUSY, fast_clock: 1'b0};
  localparam sdspi_pkg::res_t ResWake = '{
    tx_byte: sdspi_pkg::IdleByte, want_transfer: 1'b1, select_card: 1'b0,
    data_valid: 1'b0, data_byte: 8'h00, last_data: 1'b0,
    status: sdspi_pkg::ST_BUSY, fast_clock: 1'b0};

  // One directed row; typed rows carry a fixed output, the rest use the model.
  typedef struct packed {
    sdspi_pkg::mode_t             m;
    logic [sdspi_pkg::SectorW-1:0] sec;
    logic [7:0]                   rx;
    logic                         typed;
    sdspi_pkg::res_t              want;
  } dir_row_t;

  localparam int DirCount = 25;
  localparam dir_row_t DirRows [DirCount] = '{
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h00, 1'b1, ResIdle},     // transfer done while idle
    '{sdspi_pkg::MODE_NOP,  23'h7FFFFF, 8'hFF, 1'b1, ResIdle},     // mode three while idle
    '{sdspi_pkg::MODE_READ, 23'h7FFFFF, 8'h00, 1'b1, ResSelected}, // highest sector
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h00, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h7F, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h80, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_NOP,  23'h7FFFFF, 8'h00, 1'b0, '0},         // no-op item while busy
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h80, 1'b0, '0},
    '{sdspi_pkg::MODE_INIT, 23'h7FFFFF, 8'hFF, 1'b1, ResWake},     // start while busy
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_READ, 23'h000000, 8'h00, 1'b1, ResSelected}, // lowest sector, aborts
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'h00, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0},
    '{sdspi_pkg::MODE_XFER, 23'h000000, 8'hFF, 1'b0, '0}
  };

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    mode;
  logic [sdspi_pkg::SectorW-1:0] sector;
  logic [7:0]                    rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    tx_byte;
  logic                          want_transfer;
  logic                          select_card;
  logic                          data_valid;
  logic [7:0]                    data_byte;
  logic                          last_data;
  logic [1:0]                    status;
  logic                          fast_clock;

  // Host model state and its copy of the registers.
  sdspi_pkg::phase_t             hm_phase;
  sdspi_pkg::op_t                hm_op;
  logic [1:0]                    hm_step;
  int unsigned                   hm_count;
  logic [sdspi_pkg::RetryW-1:0]  hm_retries;
  logic [sdspi_pkg::PollW-1:0]   hm_polls;
  logic [7:0]                    hm_last_resp;
  logic [sdspi_pkg::AddrW-1:0]   hm_addr;
  logic                          hm_fast;
  logic [sdspi_pkg::RetryW-1:0]  cfg_retry;
  logic [sdspi_pkg::PollW-1:0]   cfg_polls;

  sdspi_pkg::res_t host_replies_due [$];
  int unsigned     mismatches;
  int unsigned     cycle_count;
  bit              idling;
  bit              hold_ask;

  sd_spi_init_and_block_read #(
    .BLOCK_BYTES(BlockBytes),
    .WAKE_BYTES (WakeBytes)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .sector       (sector),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_byte      (tx_byte),
    .want_transfer(want_transfer),
    .select_card  (select_card),
    .data_valid   (data_valid),
    .data_byte    (data_byte),
    .last_data    (last_data),
    .status       (status),
    .fast_clock   (fast_clock)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run takes far longer than any correct run could.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_sd_spi_init_and_block_read NOT OK");
      $finish;
    end
  end

  // A register value of zero behaves as one.
  function automatic logic [sdspi_pkg::RetryW-1:0] retry_cap();
    return (cfg_retry == '0) ? 20'd1 : cfg_retry;
  endfunction

  function automatic logic [sdspi_pkg::PollW-1:0] poll_cap();
    return (cfg_polls == '0) ? 8'd1 : cfg_polls;
  endfunction

  // Byte of the command frame at the current position.
  function automatic logic [7:0] frame_byte();
    logic [7:0]                  cmd;
    logic [7:0]                  crc;
    logic [sdspi_pkg::AddrW-1:0] arg;
    if (hm_op == sdspi_pkg::OP_READ) begin
      cmd = sdspi_pkg::Cmd17Byte; arg = hm_addr;            crc = sdspi_pkg::DummyCrc;
    end else if (hm_step == 2'd0) begin
      cmd = sdspi_pkg::Cmd0Byte;  arg = '0;                 crc = sdspi_pkg::Cmd0Crc;
    end else if (hm_step == 2'd1) begin
      cmd = sdspi_pkg::Cmd1Byte;  arg = '0;                 crc = sdspi_pkg::Cmd1Crc;
    end else begin
      cmd = sdspi_pkg::Cmd16Byte; arg = sdspi_pkg::Cmd16Arg; crc = sdspi_pkg::DummyCrc;
    end
    case (hm_count)
      0: return cmd;
      1: return arg[31:24];
      2: return arg[23:16];
      3: return arg[15:8];
      4: return arg[7:0];
      default: return crc;
    endcase
  endfunction

  // Advance the host model by one item and return the output it leads to.
  function automatic sdspi_pkg::res_t host_step(sdspi_pkg::mode_t m,
                                                logic [sdspi_pkg::SectorW-1:0] sec,
                                                logic [7:0] rx);
    sdspi_pkg::res_t r;
    logic [7:0]      good_resp;
    r = ResSelected;
    case (m)
      sdspi_pkg::MODE_INIT: begin
        hm_fast      = 1'b0;
        hm_op        = sdspi_pkg::OP_INIT;
        hm_phase     = sdspi_pkg::PH_WAKE;
        hm_step      = 2'd0;
        hm_count     = 0;
        hm_retries   = '0;
        hm_polls     = '0;
        hm_last_resp = '0;
      end
      sdspi_pkg::MODE_READ: begin
        hm_op      = sdspi_pkg::OP_READ;
        hm_addr    = {sec, 9'd0};
        hm_phase   = sdspi_pkg::PH_PRE;
        hm_count   = 0;
        hm_retries = '0;
        hm_polls   = '0;
      end
      sdspi_pkg::MODE_XFER: begin
        case (hm_phase)
          sdspi_pkg::PH_WAKE: begin
            hm_count++;
            if (hm_count >= WakeBytes) begin
              hm_phase = sdspi_pkg::PH_PRE;
              hm_count = 0;
            end
          end
          sdspi_pkg::PH_PRE: begin
            hm_count++;
            if (hm_count >= sdspi_pkg::PreBytes) begin
              hm_phase = sdspi_pkg::PH_CMD;
              hm_count = 0;
            end
          end
          sdspi_pkg::PH_CMD: begin
            hm_count++;
            if (hm_count >= sdspi_pkg::CmdBytes) begin
              hm_phase = sdspi_pkg::PH_POLL;
              hm_count = 0;
              hm_polls = '0;
            end
          end
          sdspi_pkg::PH_POLL: begin
            hm_polls++;
            hm_last_resp = rx;
            if (!rx[7] || hm_polls >= poll_cap()) hm_phase = sdspi_pkg::PH_TRAIL;
          end
          sdspi_pkg::PH_TRAIL: begin
            hm_count = 0;
            if (hm_op == sdspi_pkg::OP_READ) begin
              hm_phase   = sdspi_pkg::PH_TOKEN;
              hm_retries = '0;
            end else begin
              hm_phase = sdspi_pkg::PH_DESEL;
            end
          end
          sdspi_pkg::PH_DESEL: begin
            hm_count++;
            if (hm_count >= sdspi_pkg::PostBytes) begin
              hm_count = 0;
              if (hm_op == sdspi_pkg::OP_READ) begin
                hm_phase = sdspi_pkg::PH_IDLE;
                hm_op    = sdspi_pkg::OP_NONE;
                r.status = sdspi_pkg::ST_READ_DONE;
              end else begin
                // End of an init command: retry, move on, or finish.
                good_resp = (hm_step == 2'd0) ? sdspi_pkg::RespIdle : sdspi_pkg::RespReady;
                hm_retries++;
                if (hm_last_resp == good_resp || hm_retries >= retry_cap()) begin
                  if (hm_step < 2'd2) begin
                    hm_step++;
                    hm_retries = '0;
                    hm_phase   = sdspi_pkg::PH_PRE;
                  end else begin
                    hm_fast  = (hm_last_resp == sdspi_pkg::RespReady);
                    hm_phase = sdspi_pkg::PH_IDLE;
                    hm_op    = sdspi_pkg::OP_NONE;
                    r.status = (hm_last_resp == sdspi_pkg::RespReady) ?
                               sdspi_pkg::ST_INIT_OK : sdspi_pkg::ST_INIT_FAIL;
                  end
                end else begin
                  hm_phase = sdspi_pkg::PH_PRE;
                end
              end
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            hm_retries++;
            if (rx == sdspi_pkg::TokenByte || hm_retries >= retry_cap()) begin
              hm_phase = sdspi_pkg::PH_DATA;
              hm_count = 0;
            end
          end
          sdspi_pkg::PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_byte  = rx;
            hm_count++;
            if (hm_count >= BlockBytes) begin
              r.last_data = 1'b1;
              hm_phase    = sdspi_pkg::PH_TAIL;
              hm_count    = 0;
            end
          end
          sdspi_pkg::PH_TAIL: begin
            hm_count++;
            if (hm_count >= sdspi_pkg::TailBytes) begin
              hm_phase = sdspi_pkg::PH_DESEL;
              hm_count = 0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // Output levels follow the phase reached.
    case (hm_phase)
      sdspi_pkg::PH_IDLE: begin
        r.want_transfer = 1'b0;
        r.select_card   = 1'b0;
      end
      sdspi_pkg::PH_WAKE, sdspi_pkg::PH_DESEL: r.select_card = 1'b0;
      sdspi_pkg::PH_CMD:                       r.tx_byte = frame_byte();
      default: ;
    endcase
    r.fast_clock = hm_fast;
    return r;
  endfunction

  // Behavioural card: picks the next item from what the host is doing now.
  function automatic void card_item(output sdspi_pkg::mode_t m,
                                    output logic [sdspi_pkg::SectorW-1:0] sec,
                                    output logic [7:0] rx);
    int unsigned roll;
    int unsigned noise;
    m     = sdspi_pkg::MODE_XFER;
    rx    = 8'($urandom);
    noise = (hm_phase == sdspi_pkg::PH_DATA || hm_phase == sdspi_pkg::PH_TOKEN) ? 1 : 50;
    case ($urandom_range(7))
      0:       sec = '0;
      1:       sec = '1;
      default: sec = sdspi_pkg::SectorW'($urandom);
    endcase
    if (hm_phase == sdspi_pkg::PH_IDLE) begin
      case ($urandom_range(9))
        0:             m = sdspi_pkg::MODE_XFER;
        1:             m = sdspi_pkg::MODE_NOP;
        2, 3, 4, 5:    m = sdspi_pkg::MODE_INIT;
        default:       m = sdspi_pkg::MODE_READ;
      endcase
    end else if ($urandom_range(1999) < noise) begin
      m = sdspi_pkg::mode_t'($urandom_range(3));
    end else begin
      roll = $urandom_range(99);
      case (hm_phase)
        sdspi_pkg::PH_POLL: begin
          if (roll < 55)
            rx = (hm_op == sdspi_pkg::OP_INIT && hm_step == 2'd0) ?
                 sdspi_pkg::RespIdle : sdspi_pkg::RespReady;
          else if (roll < 85)
            rx = {1'b1, 7'($urandom)};
          else
            rx = {1'b0, 7'($urandom)};
        end
        sdspi_pkg::PH_TOKEN: begin
          if (roll < 35)      rx = sdspi_pkg::TokenByte;
          else if (roll < 80) rx = sdspi_pkg::IdleByte;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void reset_host_model();
    cfg_retry    = sdspi_pkg::RetryLimitReset;
    cfg_polls    = sdspi_pkg::ResponsePollsReset;
    hm_phase     = sdspi_pkg::PH_IDLE;
    hm_op        = sdspi_pkg::OP_NONE;
    hm_step      = 2'd0;
    hm_count     = 0;
    hm_retries   = '0;
    hm_polls     = '0;
    hm_last_resp = '0;
    hm_addr      = '0;
    hm_fast      = 1'b0;
  endfunction

  // Offer one item, wait for its transfer, then record the output it is due.
  task automatic send_item(sdspi_pkg::mode_t m, logic [sdspi_pkg::SectorW-1:0] sec,
                           logic [7:0] rx, logic typed, sdspi_pkg::res_t typed_res);
    sdspi_pkg::res_t r;
    if (idling && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    sector   <= sec;
    rx_byte  <= rx;
    do @(posedge clk); while (in_stall);
    r = host_step(m, sec, rx);
    host_replies_due.push_back(typed ? typed_res : r);
  endtask

  // Stop offering and wait until every due output has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (host_replies_due.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == sdspi_pkg::REG_RETRY_LIMIT) cfg_retry = value[sdspi_pkg::RetryW-1:0];
    else cfg_polls = value[sdspi_pkg::PollW-1:0];
    @(posedge clk);
  endtask

  task automatic report(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  // Output side: stall in random bursts, or hold off for a long stretch.
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling && $urandom_range(5) == 0) begin
        n = $urandom_range(15, 1);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(20, 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each output transfer with the oldest due output.
  always @(posedge clk) begin : result_check
    sdspi_pkg::res_t got;
    sdspi_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{tx_byte, want_transfer, select_card, data_valid, data_byte, last_data,
              sdspi_pkg::status_t'(status), fast_clock};
      if (host_replies_due.size() == 0) begin
        $display("%0t: output transfer with none due, got 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = host_replies_due.pop_front();
        if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
        if (got.want_transfer !== want.want_transfer)
          report("want_transfer", want.want_transfer, got.want_transfer);
        if (got.select_card !== want.select_card)
          report("select_card", want.select_card, got.select_card);
        if (got.data_valid !== want.data_valid)
          report("data_valid", want.data_valid, got.data_valid);
        if (got.data_byte !== want.data_byte) report("data_byte", want.data_byte, got.data_byte);
        if (got.last_data !== want.last_data) report("last_data", want.last_data, got.last_data);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.fast_clock !== want.fast_clock)
          report("fast_clock", want.fast_clock, got.fast_clock);
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases under several settings.
  initial begin : stimulus
    logic [sdspi_pkg::RetryW-1:0]  set_retry [NumPhases];
    logic [sdspi_pkg::PollW-1:0]   set_polls [NumPhases];
    int unsigned                   set_items [NumPhases];
    sdspi_pkg::mode_t              m;
    logic [sdspi_pkg::SectorW-1:0] sec;
    logic [7:0]                    rx;

    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    mode      = sdspi_pkg::MODE_NOP;
    sector    = '0;
    rx_byte   = '0;
    out_stall = 1'b0;
    idling    = 1'b1;
    hold_ask  = 1'b0;
    mismatches = 0;
    reset_host_model();

    // Settings per phase: top extremes, bottom, zero, a few random, reset values.
    set_retry[0] = 20'hFFFFF; set_polls[0] = 8'd255; set_items[0] = 560;
    set_retry[1] = 20'd1;     set_polls[1] = 8'd1;   set_items[1] = 100;
    set_retry[2] = 20'd0;     set_polls[2] = 8'd0;   set_items[2] = 100;
    for (int p = 3; p < 6; p++) begin
      set_retry[p] = 20'($urandom_range(6, 1));
      set_polls[p] = 8'($urandom_range(12, 1));
      set_items[p] = 100;
    end
    set_retry[6] = sdspi_pkg::RetryLimitReset;
    set_polls[6] = sdspi_pkg::ResponsePollsReset;
    set_items[6] = 120;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirCount; i++)
      send_item(DirRows[i].m, DirRows[i].sec, DirRows[i].rx, DirRows[i].typed,
                DirRows[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(sdspi_pkg::REG_RETRY_LIMIT, 32'(set_retry[p]));
      write_reg(sdspi_pkg::REG_RESPONSE_POLLS, 32'(set_polls[p]));
      // The last phase runs at full rate on both sides.
      if (p == NumPhases - 1) idling = 1'b0;
      for (int i = 0; i < set_items[p]; i++) begin
        if (p == 0 && i == 40) hold_ask = 1'b1;
        if (p == 0 && i == 300) drain();
        card_item(m, sec, rx);
        send_item(m, sec, rx, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb_sd_spi_init_and_block_read OK");
    else
      $display("tb_sd_spi_init_and_block_read NOT OK");
    $finish;
  end

endmodule
